// ----- design/sctpm_pkg.sv -----
// ----------------------------------------------------------------------------
// sctpm_pkg
// Types and constants shared by the servo channel table and pulse mapper.
// ----------------------------------------------------------------------------
package sctpm_pkg;

    localparam int PIN_W     = 6;
    localparam int PULSE_W   = 15;
    localparam int PERIOD_W  = 16;
    localparam int SPEED_W   = 8;
    localparam int CH_W      = 4;

    // Operation codes carried in the action field.
    localparam logic ACT_REGISTER = 1'b0;
    localparam logic ACT_ORDER    = 1'b1;

    // Speed mapping: pulse = min + (max - min) * (NEUTRAL +/- speed) / SCALE.
    localparam int K_W     = 10;                   // signed factor, -155 .. 355
    localparam int DIFF_W  = PULSE_W + 1;          // signed max - min
    localparam int PROD_W  = 26;                   // signed diff * factor
    localparam logic signed [K_W-1:0]    NEUTRAL = 10'sd100;
    localparam logic signed [PROD_W-1:0] SCALE   = 26'sd200;

    // Division of the in-range product by 200: drop three bits, then divide
    // by 25 through a reciprocal that is exact for a 20-bit dividend.
    localparam int QIN_W    = 20;
    localparam int RECIP_SH = 25;
    localparam int RECIP_W  = 21;
    localparam logic [RECIP_W-1:0] RECIP25 = 21'd1342178;   // ceil(2^25 / 25)

    typedef struct packed {
        logic                action;
        logic [PIN_W-1:0]    pin;
        logic [PULSE_W-1:0]  min_pulse_us;
        logic [PULSE_W-1:0]  max_pulse_us;
        logic [SPEED_W-1:0]  speed_percent;
        logic                forward;
    } req_t;

    typedef struct packed {
        logic                accepted;
        logic [CH_W-1:0]     channel;
        logic [PULSE_W-1:0]  pulse_us;
        logic [PERIOD_W-1:0] period_us;
    } rsp_t;

    typedef struct packed {
        logic [PIN_W-1:0]    pin;
        logic [PULSE_W-1:0]  min_pulse;
        logic [PULSE_W-1:0]  max_pulse;
    } entry_t;

    // How the final pulse is chosen.
    typedef enum logic [1:0] {
        PICK_MAX,
        PICK_MIN,
        PICK_QUOT
    } pick_t;

endpackage

// ----- design/servo_channel_table_pulse_mapper_unit.sv -----
// ----------------------------------------------------------------------------
// servo_channel_table_pulse_mapper_unit
// Servo channel table with registration and speed-to-pulse mapping.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the req channel (req_valid / req_ready / req) and
// each produces exactly one item on the rsp channel (rsp_valid / rsp_ready /
// rsp). A registration item stores pin, minimum and maximum pulse in the next
// free channel and answers with the channel index and the PWM period; when
// all CHANNELS entries are used it is refused with an all-zero item. An order
// item looks up the lowest valid channel with the given pin and answers with
// the pulse width, clamped to the channel's range, or is refused when the pin
// is unknown.
// A registration item goes from acceptance straight to the emit state and its
// result is then registered at the output. An order walks the channel table
// one entry per cycle through the table memory's single read port, then passes
// the multiply state and the clamp and divide by 200 state before the emit
// state; when the pin is unknown the walk goes straight to the emit state.
// One item is processed at a time; a new item is taken once the previous one
// has reached the output register.
// Reset clears the valid bits and the fill count; the table memory itself is
// not cleared, as only valid entries are matched. When the receiver
// stalls, the result waits in the output register and the next item is still
// accepted and worked on until its own result is ready to be handed over.
// ----------------------------------------------------------------------------
module servo_channel_table_pulse_mapper_unit
    import sctpm_pkg::*;
#(
    parameter int CHANNELS = 12
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(CHANNELS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_MUL,
        S_DIV,
        S_EMIT
    } state_t;

    state_t state_reg;

    // Table memory: one entry per channel, synchronous read.
    entry_t table_mem [CHANNELS];
    entry_t rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;

    logic [CHANNELS-1:0] valid_reg;
    logic [CNT_W-1:0]    used_count_reg;

    // Item being worked on.
    req_t              item_reg;
    logic [IDX_W-1:0]  scan_idx_reg;
    logic [PULSE_W-1:0] lo_reg;
    logic [PULSE_W-1:0] hi_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] lim_reg;
    pick_t              pick_reg;
    logic [PULSE_W-1:0] quot_reg;
    rsp_t               res_reg;

    logic   rsp_valid_reg;
    rsp_t   rsp_reg;
    rsp_t   emit_rsp;

    logic accept;
    logic scan_last;
    logic hit;
    logic table_full;
    logic out_free;

    logic signed [DIFF_W-1:0] diff;
    logic signed [K_W-1:0]    factor;
    logic signed [PROD_W-1:0] diff_ext;
    logic signed [PROD_W-1:0] factor_ext;
    logic [QIN_W-1:0]                 qin;
    logic [QIN_W+RECIP_W-1:0]         qprod;
    logic [PULSE_W-1:0]               pulse;

    assign req_ready  = (state_reg == S_IDLE);
    assign accept     = req_valid && req_ready;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;
    assign out_free   = !rsp_valid_reg || rsp_ready;

    assign table_full = (used_count_reg >= CNT_W'(CHANNELS));
    assign scan_last  = (scan_idx_reg == IDX_W'(CHANNELS - 1));
    assign hit        = valid_reg[scan_idx_reg] && (rd_data_reg.pin == item_reg.pin);

    // Entry 0 is fetched while the item is accepted; the walk then fetches
    // the entry after the one it is looking at.
    always_comb
    begin
        if (state_reg == S_WALK && !scan_last)
        begin
            rd_addr = scan_idx_reg + IDX_W'(1);
        end
        else
        begin
            rd_addr = '0;
        end
    end

    assign wr_en   = accept && (req.action == ACT_REGISTER) && !table_full;
    assign wr_addr = used_count_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= '{pin:       req.pin,
                                    min_pulse: req.min_pulse_us,
                                    max_pulse: req.max_pulse_us};
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    // Signed spread and speed factor of the matched channel.
    assign diff   = $signed({1'b0, hi_reg}) - $signed({1'b0, lo_reg});
    assign factor = item_reg.forward
                  ? NEUTRAL + $signed({2'b00, item_reg.speed_percent})
                  : NEUTRAL - $signed({2'b00, item_reg.speed_percent});
    assign diff_ext   = PROD_W'(diff);
    assign factor_ext = PROD_W'(factor);

    // In range the product lies in [0, diff * 200], below 2^23, so its low
    // three bits drop out of the divide by 200 and the rest is divided by 25.
    assign qin   = prod_reg[QIN_W+2:3];
    assign qprod = {{RECIP_W{1'b0}}, qin} * {{QIN_W{1'b0}}, RECIP25};

    always_comb
    begin
        case (pick_reg)
            PICK_MAX:  pulse = hi_reg;
            PICK_MIN:  pulse = lo_reg;
            PICK_QUOT: pulse = lo_reg + quot_reg;
            default:   pulse = lo_reg;
        endcase
    end

    // Only an executed order carries a pulse width.
    always_comb
    begin
        emit_rsp = res_reg;
        if (item_reg.action == ACT_ORDER && res_reg.accepted)
        begin
            emit_rsp.pulse_us = pulse;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            used_count_reg <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
            item_reg       <= '0;
            scan_idx_reg   <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            prod_reg       <= '0;
            lim_reg        <= '0;
            pick_reg       <= PICK_MIN;
            quot_reg       <= '0;
            res_reg        <= '0;
        end
        else
        begin
            if (state_reg == S_EMIT && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg     <= req;
                        scan_idx_reg <= '0;
                        if (req.action == ACT_REGISTER && !table_full)
                        begin
                            valid_reg[wr_addr] <= 1'b1;
                            used_count_reg     <= used_count_reg + CNT_W'(1);
                            res_reg <= '{accepted:  1'b1,
                                         channel:   CH_W'(wr_addr),
                                         pulse_us:  '0,
                                         period_us: {1'b0, req.min_pulse_us}
                                                  + {1'b0, req.max_pulse_us}};
                        end
                        else
                        begin
                            res_reg <= '0;
                        end
                        if (req.action == ACT_REGISTER)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_WALK;
                        end
                    end
                end

                S_WALK:
                begin
                    if (hit)
                    begin
                        lo_reg    <= rd_data_reg.min_pulse;
                        hi_reg    <= rd_data_reg.max_pulse;
                        res_reg   <= '{accepted:  1'b1,
                                       channel:   CH_W'(scan_idx_reg),
                                       pulse_us:  '0,
                                       period_us: '0};
                        state_reg <= S_MUL;
                    end
                    else if (scan_last)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                    end
                end

                S_MUL:
                begin
                    prod_reg  <= diff_ext * factor_ext;
                    lim_reg   <= diff_ext * SCALE;
                    state_reg <= S_DIV;
                end

                S_DIV:
                begin
                    // Above max first, then below min, else truncate.
                    if (prod_reg > lim_reg)
                    begin
                        pick_reg <= PICK_MAX;
                    end
                    else if (prod_reg < 0)
                    begin
                        pick_reg <= PICK_MIN;
                    end
                    else
                    begin
                        pick_reg <= PICK_QUOT;
                    end
                    quot_reg  <= qprod[RECIP_SH+PULSE_W-1:RECIP_SH];
                    state_reg <= S_EMIT;
                end

                S_EMIT:
                begin
                    if (out_free)
                    begin
                        rsp_reg   <= emit_rsp;
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
